// ----- rtl/bmpblit_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpblit_pkg
// Shared types and constants of the 4-bit BMP to frame buffer blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpblit_pkg;

   typedef enum logic [7:0] {
      CSR_DEST_X        = 8'd0,
      CSR_DEST_Y        = 8'd1,
      CSR_WINDOW_WIDTH  = 8'd2,
      CSR_WINDOW_HEIGHT = 8'd3
   } csr_index_type;

   localparam logic [31:0] OFFSET_FIRST_POS = 32'd10;
   localparam logic [31:0] OFFSET_LAST_POS  = 32'd13;
   localparam logic [31:0] HEADER_MIN       = 32'd14;
   localparam logic [31:0] POSITION_MAX     = 32'hFFFF_FFFF;

   localparam logic [8:0] DEST_X_RESET        = 9'd0;
   localparam logic [7:0] DEST_Y_RESET        = 8'd0;
   localparam logic [8:0] WINDOW_WIDTH_RESET  = 9'd320;
   localparam logic [7:0] WINDOW_HEIGHT_RESET = 8'd240;

endpackage

`default_nettype wire

// ----- rtl/bmp_to_framebuffer_blit.sv -----
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit
// Turns a 4-bit-per-pixel BMP byte stream into inverted, row-flipped frame
// buffer writes placed at a programmable window.
//
//   channel  direction  word                          handshake
//   req      in         file byte, tuser first flag   req_tvalid / req_tready
//   rsp      out        address, pixel pair, tlast    rsp_tvalid / rsp_tready
//   csr      in         register index and data       csr_valid / csr_ready
//
// One word is taken per cycle while rsp is not stalled. A pixel byte passes
// through the counter stage, then the address multiply and bound compare, to rsp.
// The reset is synchronous and loads the register defaults; it also acts as
// the start of a file. A stall on rsp backs up through both stages to req.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_to_framebuffer_blit #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] file_byte
   input  wire logic [0:0]  req_tuser,   // [0] first_of_file
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [15:0] fb_address, [23:16] pixel_pair
   output logic             rsp_tlast,   // last_write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   import bmpblit_pkg::*;

   localparam int HALF_WIDTH = SCREEN_WIDTH / 2;
   localparam int LIMIT      = HALF_WIDTH * SCREEN_HEIGHT;
   localparam int MAX_ADDR   = 509 * HALF_WIDTH + 510;
   localparam int BITS_ADDR  = $clog2(MAX_ADDR + 1);
   localparam int BITS_LIMIT = $clog2(LIMIT + 1);
   localparam int BITS_BOTH  = (BITS_ADDR > BITS_LIMIT) ? BITS_ADDR : BITS_LIMIT;
   localparam int ADDR_W     = (BITS_BOTH > 16) ? BITS_BOTH : 16;

   logic [8:0]  dest_x_ff;
   logic [7:0]  dest_y_ff;
   logic [8:0]  window_width_ff;
   logic [7:0]  window_height_ff;

   logic [31:0] byte_position_ff, byte_position_in;
   logic [31:0] data_offset_ff, data_offset_in;
   logic [7:0]  column_count_ff, column_count_in;
   logic [7:0]  row_count_ff, row_count_in;
   logic        window_done_ff, window_done_in;

   logic        s1_valid_ff;
   logic [8:0]  s1_row_ff;
   logic [8:0]  s1_col_ff;
   logic [7:0]  s1_pixel_ff;
   logic        s1_last_ff;

   logic        out_valid_ff;
   logic [15:0] out_addr_ff;
   logic [7:0]  out_pixel_ff;
   logic        out_last_ff;

   logic        req_accept;
   logic        s1_advance;
   logic        out_advance;

   logic        first;
   logic [31:0] pos;
   logic [31:0] offset_cur;
   logic [31:0] start;
   logic [7:0]  column_cur;
   logic [7:0]  row_cur;
   logic        done_cur;
   logic [7:0]  bytes_per_row;
   logic        emit;
   logic        wrap;
   logic [8:0]  row_next;
   logic        last;
   logic [8:0]  row_dst;
   logic [8:0]  col_dst;

   logic [ADDR_W-1:0] addr;
   logic              in_range;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff        <= DEST_X_RESET;
         dest_y_ff        <= DEST_Y_RESET;
         window_width_ff  <= WINDOW_WIDTH_RESET;
         window_height_ff <= WINDOW_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_X:        dest_x_ff        <= csr_data;
            CSR_DEST_Y:        dest_y_ff        <= csr_data[7:0];
            CSR_WINDOW_WIDTH:  window_width_ff  <= csr_data;
            CSR_WINDOW_HEIGHT: window_height_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign out_advance = !out_valid_ff || rsp_tready;
   assign s1_advance  = !s1_valid_ff || out_advance;
   assign req_tready  = s1_advance;
   assign req_accept  = req_tvalid && req_tready;

   always_comb begin
      first      = req_tuser[0];
      pos        = first ? '0 : byte_position_ff;
      offset_cur = first ? '0 : data_offset_ff;
      column_cur = first ? '0 : column_count_ff;
      row_cur    = first ? '0 : row_count_ff;
      done_cur   = first ? 1'b0 : window_done_ff;

      byte_position_in = (pos == POSITION_MAX) ? pos : pos + 32'd1;
      start            = (offset_cur < HEADER_MIN) ? HEADER_MIN : offset_cur;
      bytes_per_row    = window_width_ff[8:1];

      data_offset_in  = offset_cur;
      column_count_in = column_cur;
      row_count_in    = row_cur;
      window_done_in  = done_cur;
      emit            = 1'b0;
      wrap            = ({1'b0, column_cur} + 9'd1) >= {1'b0, bytes_per_row};
      row_next        = {1'b0, row_cur} + {8'd0, wrap};
      last            = row_next >= {1'b0, window_height_ff};
      row_dst         = {1'b0, dest_y_ff} + {1'b0, window_height_ff}
                        - 9'd1 - {1'b0, row_cur};
      col_dst         = {1'b0, dest_x_ff[8:1]} + {1'b0, column_cur};

      if (pos >= OFFSET_FIRST_POS && pos <= OFFSET_LAST_POS) begin
         case (pos[1:0])
            2'b10: data_offset_in[7:0]   = req_tdata;
            2'b11: data_offset_in[15:8]  = req_tdata;
            2'b00: data_offset_in[23:16] = req_tdata;
            2'b01: data_offset_in[31:24] = req_tdata;
            default: ;
         endcase
      end else if (pos >= start && !done_cur) begin
         if (bytes_per_row == 8'd0 || window_height_ff == 8'd0 ||
             row_cur >= window_height_ff) begin
            window_done_in = 1'b1;
         end else begin
            column_count_in = wrap ? 8'd0 : column_cur + 8'd1;
            row_count_in    = row_next[7:0];
            if (last) begin
               window_done_in = 1'b1;
            end
            emit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         data_offset_ff   <= '0;
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         window_done_ff   <= 1'b0;
      end else if (req_accept) begin
         byte_position_ff <= byte_position_in;
         data_offset_ff   <= data_offset_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         window_done_ff   <= window_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s1_valid_ff <= req_accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_row_ff   <= row_dst;
         s1_col_ff   <= col_dst;
         s1_pixel_ff <= ~req_tdata;
         s1_last_ff  <= last;
      end
   end

   assign addr     = ADDR_W'(s1_row_ff) * ADDR_W'(HALF_WIDTH) + ADDR_W'(s1_col_ff);
   assign in_range = addr < ADDR_W'(LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_advance) begin
         out_valid_ff <= s1_valid_ff && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance) begin
         out_addr_ff  <= addr[15:0];
         out_pixel_ff <= s1_pixel_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pixel_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/bmpblit_checker.sv -----
// ----------------------------------------------------------------------------
// bmpblit_checker
// Port-level checks on the blitter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpblit_checker #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   localparam longint LIMIT = longint'(SCREEN_WIDTH / 2) * longint'(SCREEN_HEIGHT);
   localparam bit LIMIT_WIDE = LIMIT > 65535;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> LIMIT_WIDE || (longint'(rsp_tdata[15:0]) < LIMIT))
      else $error("write address outside the frame buffer");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("write appeared without a byte taken two cycles earlier");

endmodule

bind bmp_to_framebuffer_blit bmpblit_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bmpblit_checker (.*);

`default_nettype wire
